@@ src/mtk_pkg.sv @@
// Package for the keystream XOR block: item types, generator constants,
// back-end state encoding and the tempering function. No dependencies.
package mtk_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned TWIST_FAR   = 397;
  localparam int unsigned TWIST_WRAP  = STATE_WORDS - TWIST_FAR;  // 227

  localparam logic [31:0] SEED_MULT = 32'h6c07_8965;
  localparam logic [31:0] TWIST_MAG = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(STATE_WORDS - 1);
  localparam logic [POS_W-1:0] WRAP_POS  = POS_W'(TWIST_WRAP);
  localparam logic [POS_W-1:0] FAR_STEP  = POS_W'(TWIST_FAR);

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] seed;
    logic [7:0]  data_byte;
    logic        end_of_block;
  } req_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic valid;
    req_t item;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_RD_NXT,
    ST_RD_FAR,
    ST_CAP_FAR,
    ST_FINISH
  } back_state_t;

  typedef struct packed {
    back_state_t state;
    pos_t        pos;
    logic        pop;
    logic        out_load;
  } back_status_t;

  function automatic logic [31:0] temper(input logic [31:0] r);
    logic [31:0] t;
    t = r ^ (r >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

@@ src/mtk_if.sv @@
// Valid/ready channel interfaces for the request and result streams.
// Depends on nothing.
interface mtk_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] seed;
  logic [7:0]  data_byte;
  logic        end_of_block;

  modport source(output valid, req_type, seed, data_byte, end_of_block, input ready);
  modport sink(input valid, req_type, seed, data_byte, end_of_block, output ready);
endinterface

interface mtk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       end_of_block_out;

  modport source(output valid, result_byte, end_of_block_out, input ready);
  modport sink(input valid, result_byte, end_of_block_out, output ready);
endinterface

@@ src/mtk_front.sv @@
// Front end: accepts request transactions into a two-entry queue.
// Depends on mtk_pkg and mtk_in_if.
module mtk_front
  import mtk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mtk_in_if.sink    in_ch,
  output q_head_t   head,
  input  logic      pop
);

  req_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  assign head.valid = (count_r != 2'd0);
  assign head.item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ (pop && head.valid);
    count_nxt  = count_r + 2'(push) - 2'(pop && head.valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{req_type:     in_ch.req_type,
                            seed:         in_ch.seed,
                            data_byte:    in_ch.data_byte,
                            end_of_block: in_ch.end_of_block};
    end
  end

endmodule

@@ src/mtk_back.sv @@
// Back end: generator state memory, seeding sequencer, on-demand twist,
// tempering and the result register. Depends on mtk_pkg and mtk_out_if.
module mtk_back
  import mtk_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  q_head_t      head,
  output logic         pop,
  mtk_out_if.source    out_ch,
  output back_status_t status
);

  logic [31:0] mem [STATE_WORDS];
  logic [31:0] rdata_r;
  pos_t        rd_addr;
  logic        we;
  pos_t        wr_addr;
  logic [31:0] wr_data;

  back_state_t state_r, state_nxt;
  pos_t        pos_r, pos_nxt;
  pos_t        idx_r, idx_nxt;
  logic [31:0] x_r, x_nxt;
  logic        seeded_r, seeded_nxt;
  logic [31:0] cur_r, nxt_r, far_r;
  logic [7:0]  byte_r;
  logic        eob_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_eob_r;
  logic        out_free;
  logic        out_load;
  logic [31:0] seed_prod;
  logic [31:0] seed_word;
  logic [31:0] y, twisted, tempered;
  pos_t        pos_next1, pos_far;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  assign pos_next1 = (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
  assign pos_far   = (pos_r < WRAP_POS) ? pos_r + FAR_STEP : pos_r - WRAP_POS;

  assign seed_prod = SEED_MULT * (x_r ^ (x_r >> 30));
  assign seed_word = seed_prod + 32'(idx_r);

  // in-place twist of the word about to be drawn
  assign y        = {cur_r[31], nxt_r[30:0]};
  assign twisted  = far_r ^ (y >> 1) ^ (y[0] ? TWIST_MAG : 32'h0);
  assign tempered = temper(twisted);

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    seeded_nxt    = seeded_r;
    pop           = 1'b0;
    out_load      = 1'b0;
    we            = 1'b0;
    wr_addr       = idx_r;
    wr_data       = seed_word;
    rd_addr       = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.req_type == REQ_SEED) begin
            we        = 1'b1;
            wr_addr   = '0;
            wr_data   = head.item.seed;
            x_nxt     = head.item.seed;
            idx_nxt   = pos_t'(1);
            state_nxt = ST_SEED;
          end else if (seeded_r) begin
            state_nxt = ST_RD_NXT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SEED: begin
        we    = 1'b1;
        x_nxt = seed_word;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_POS) begin
          seeded_nxt = 1'b1;
          pos_nxt    = '0;
          state_nxt  = ST_IDLE;
        end
      end
      ST_RD_NXT: begin
        rd_addr   = pos_next1;
        state_nxt = ST_RD_FAR;
      end
      ST_RD_FAR: begin
        rd_addr   = pos_far;
        state_nxt = ST_CAP_FAR;
      end
      ST_CAP_FAR: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          we        = seeded_r;
          wr_addr   = pos_r;
          wr_data   = twisted;
          pos_nxt   = pos_next1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    x_r   <= x_nxt;
    if (pop) begin
      byte_r <= head.item.data_byte;
      eob_r  <= head.item.end_of_block;
    end
    if (state_r == ST_RD_NXT) cur_r <= rdata_r;
    if (state_r == ST_RD_FAR) nxt_r <= rdata_r;
    if (state_r == ST_CAP_FAR) far_r <= rdata_r;
    if (out_load) begin
      out_byte_r <= byte_r ^ (seeded_r ? tempered[8:1] : 8'h00);
      out_eob_r  <= eob_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_byte      = out_byte_r;
  assign out_ch.end_of_block_out = out_eob_r;

  assign status = '{state: state_r, pos: pos_r, pop: pop, out_load: out_load};

endmodule

@@ src/mt19937_keystream_xor.sv @@
// Top level of the MT19937 keystream XOR cipher: front queue plus back end.
// Depends on mtk_pkg, mtk_if, mtk_front and mtk_back.
//
// Byte stream cipher on an MT19937 generator. A seed transaction (req_type 0)
// refills the 624-word state and gives no result; it occupies the back end
// while it writes one state word per cycle, all but the first through the
// seeding multiplier. A data transaction (req_type 1) draws the next tempered
// word and returns data_byte XOR bits 8..1 of it, with end_of_block copied to
// end_of_block_out. The twist runs on demand, one word per draw, so a data
// transaction steps the back end through ST_RD_NXT, ST_RD_FAR, ST_CAP_FAR
// and ST_FINISH: three reads of the state memory on successive cycles, a
// state for the last registered read to land, and a final state that writes
// back the twisted word and loads the result. Before the first seed the
// keystream is zero and a data transaction goes from ST_IDLE straight to
// ST_FINISH, as no state word is used or written. A two-entry queue in front
// accepts until full while the back end is busy; a result register lets the
// back end carry the next transaction to ST_FINISH and hold there until the
// result is taken. After reset the block is ready at once, with no clearing pass.
module mt19937_keystream_xor
  import mtk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mtk_in_if.sink     in_ch,
  mtk_out_if.source  out_ch
);

  q_head_t      head;
  logic         pop;
  back_status_t status;

  // accept and queue transactions
  mtk_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  // seed, twist, temper and deliver
  mtk_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch),
    .status (status)
  );

  // draw position always names a real state word
  assert property (@(posedge clk) disable iff (!rst_n)
    status.pos <= LAST_POS)
    else $error("draw position out of range");

  // pop only from a non-empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    status.pop |-> head.valid)
    else $error("pop from empty queue");

  // seeding never produces a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (status.state == ST_SEED) |-> !status.out_load)
    else $error("result during seeding");

  // a result loads only when the output side is free
  assert property (@(posedge clk) disable iff (!rst_n)
    status.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for mt19937_keystream_xor: a byte-cipher scoreboard
// plus drivers for the request and result channels. Depends on mtk_pkg and mtk_if.
module tb;
  import mtk_pkg::*;

  // Scoreboard: mirror the generator state and queue the bytes it predicts
  class keystream_board;
    typedef struct {
      logic [7:0] cipher;
      logic       eob;
    } cipher_exp_t;

    logic [31:0]   gen_words[STATE_WORDS];
    int unsigned   draw_pos;
    int unsigned   draws_left;
    cipher_exp_t   pending_bytes[$];
    int unsigned   bad_count;
    int unsigned   seeds_seen;
    int unsigned   bytes_seen;
    int unsigned   twists_seen;

    function new();
      foreach (gen_words[i]) gen_words[i] = '0;
      draw_pos    = 0;
      draws_left  = 1;
      bad_count   = 0;
      seeds_seen  = 0;
      bytes_seen  = 0;
      twists_seen = 0;
    endfunction

    function logic [31:0] scramble(input logic [31:0] r);
      logic [31:0] t;
      t = r ^ (r >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      return t ^ (t >> 18);
    endfunction

    function void twist_state();
      logic [31:0] y;
      logic [31:0] v;
      for (int i = 0; i < STATE_WORDS; i++) begin
        y = {gen_words[i][31], gen_words[(i + 1) % STATE_WORDS][30:0]};
        v = gen_words[(i + TWIST_FAR) % STATE_WORDS] ^ (y >> 1);
        if (y[0]) v = v ^ TWIST_MAG;
        gen_words[i] = v;
      end
      twists_seen++;
    endfunction

    // note an accepted request transaction
    function void note_item(input req_t it);
      logic [31:0] x;
      logic [31:0] w;
      cipher_exp_t e;
      if (it.req_type == REQ_SEED) begin
        x = it.seed;
        gen_words[0] = x;
        for (int i = 1; i < STATE_WORDS; i++) begin
          x = 32'(i) + SEED_MULT * (x ^ (x >> 30));
          gen_words[i] = x;
        end
        draw_pos   = 0;
        draws_left = 1;
        seeds_seen++;
      end else begin
        draws_left = (draws_left - 1) & 10'h3ff;
        if (draws_left == 0) begin
          twist_state();
          draws_left = STATE_WORDS;
          draw_pos   = 0;
        end
        if (draw_pos >= STATE_WORDS) draw_pos = 0;
        w = scramble(gen_words[draw_pos]);
        draw_pos = (draw_pos + 1) & 10'h3ff;
        e.cipher = it.data_byte ^ w[8:1];
        e.eob    = it.end_of_block;
        pending_bytes.push_back(e);
      end
    endfunction

    // compare a result transaction with the oldest prediction
    function void check_result(input logic [7:0] got_byte, input logic got_eob);
      cipher_exp_t e;
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result: byte %h eob %b", got_byte, got_eob);
        return;
      end
      e = pending_bytes.pop_front();
      if (got_byte !== e.cipher || got_eob !== e.eob) begin
        bad_count++;
        if (bad_count <= 10)
          $display("mismatch on result %0d: expected byte %h eob %b, got byte %h eob %b",
                   bytes_seen, e.cipher, e.eob, got_byte, got_eob);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;     // suppress random idling on both sides
  bit   timed_out;

  mtk_in_if  in_ch();
  mtk_out_if out_ch();

  keystream_board board = new();

  mt19937_keystream_xor u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Result side: stall about 16% of the time, check on every accepted transaction
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.result_byte, out_ch.end_of_block_out);
  end

  // Drive one request; hold it until the block takes it
  task automatic send_item(input logic kind, input logic [31:0] s, input logic [7:0] d,
                           input logic eob);
    req_t it;
    while (!calm && $urandom_range(99) < 16) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    it.req_type     = kind;
    it.seed         = s;
    it.data_byte    = d;
    it.end_of_block = eob;
    in_ch.valid        = 1'b1;
    in_ch.req_type     = kind;
    in_ch.seed         = s;
    in_ch.data_byte    = d;
    in_ch.end_of_block = eob;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(it);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_seed(input logic [31:0] s);
    // junk in the byte fields: the block must ignore them
    send_item(REQ_SEED, s, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] d, input logic eob);
    send_item(REQ_DATA, $urandom, d, eob);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (board.pending_bytes.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  initial begin
    int unsigned n;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_DATA;
    in_ch.seed         = '0;
    in_ch.data_byte    = '0;
    in_ch.end_of_block = 1'b0;
    out_ch.ready       = 1'b0;
    calm  = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: bytes before any seed see a zero keystream
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h5a, 1'b0);
    // Extreme seeds, each followed by extreme bytes and both marker values
    send_seed(32'h0000_0000);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'ha5, 1'b0);
    send_seed(32'hffff_ffff);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_seed(32'd5489);
    for (int i = 0; i < 6; i++) send_byte(8'(1 << i), 1'(i));
    send_seed(32'h8000_0001);
    send_seed(32'h7fff_fffe);   // back-to-back seeds, latter wins
    send_byte(8'h80, 1'b1);
    send_byte(8'h7f, 1'b0);

    // Hold the sender until everything has come back
    drain();
    repeat (700) @(negedge clk);

    // Long run from one seed crosses the twist twice, no idling in its middle
    send_seed($urandom);
    for (n = 0; n < 700; n++) begin
      calm = (n >= 200 && n < 500);
      send_byte(8'($urandom), 1'($urandom_range(7) == 0));
    end
    calm = 1'b0;

    // Random mix: mostly data, occasional reseeds
    for (n = 0; n < 430; n++) begin
      if ($urandom_range(99) < 4) send_seed($urandom);
      else send_byte(8'($urandom), 1'($urandom_range(7) == 0));
    end

    drain();
    repeat (700) @(negedge clk);
    if (timed_out) begin
      $display("CHECK FAILED");
    end else begin
      $display("covered %0d seeds, %0d result bytes, %0d full twists of the state",
               board.seeds_seen, board.bytes_seen, board.twists_seen);
      if (board.bad_count == 0 && board.pending_bytes.size() == 0) begin
        $display("CHECK OK");
      end else begin
        $display("%0d mismatches, %0d results never arrived", board.bad_count,
                 board.pending_bytes.size());
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    timed_out = 1'b0;
    #8ms;
    timed_out = 1'b1;
    $display("timeout waiting on the block");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
